>>> design/pfa_pkg.sv
package pfa_pkg;

    // Fixed field widths
    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 17;
    localparam int N_W        = FRAME_W + 1;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAME_W;

    // Default sizing
    localparam int DEF_MAX_FRAMES  = 65536;
    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_WORD_BITS   = 64;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    localparam logic [FRAME_W-1:0] RST_FRAME_BASE  = 20'd256;
    localparam logic [COUNT_W-1:0] RST_FRAME_COUNT = 17'd65536;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_OUT_OF_PAGES = 3'd1,
        ST_DOUBLE_FREE  = 3'd2,
        ST_NULL_FREE    = 3'd3,
        ST_STALE        = 3'd4,
        ST_OUT_OF_RANGE = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_CHK,
        S_SPLIT,
        S_EVAL,
        S_SC_START,
        S_SC_FIRST,
        S_SC_RD,
        S_SC_EVAL
    } t_state;

    typedef enum logic [2:0] {
        MW_NONE,
        MW_CLEAR,
        MW_FREE,
        MW_TAKE,
        MW_SCAN
    } t_map_wr;

    typedef enum logic [1:0] {
        G_NONE,
        G_FRAME,
        G_SCAN
    } t_grant;

    typedef struct packed {
        logic    accept;
        logic    pop_start;
        logic    pop_load;
        logic    mul_idx;
        logic    mul_last;
        logic    split;
        logic    first;
        logic    scan_rd;
        logic    scan_next;
        logic    clr_step;
        logic    push;
        logic    res_load;
        t_map_wr map_wr;
        t_grant  grant;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_zero;
        logic frame_zero;
        logic out_range;
        logic bit_set;
        logic n_zero;
        logic word_full;
        logic word_first;
        logic clr_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/pfa_req_if.sv
interface pfa_req_if import pfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [FRAME_W-1:0] frame;

    modport source (output valid, output action, output frame, input ready);
    modport sink   (input valid, input action, input frame, output ready);
endinterface

>>> design/pfa_rsp_if.sv
interface pfa_rsp_if import pfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  granted_frame;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_frame, output status, input ready);
    modport sink   (input valid, input granted_frame, input status, output ready);
endinterface

>>> design/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pfa_ctrl.sv
module pfa_ctrl import pfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state, n_state;
    logic   r_is_free, n_is_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_is_free <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_free <= n_is_free;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_free  = r_is_free;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.map_wr     = MW_NONE;
        o_cmd.grant      = G_NONE;
        o_cmd.res_status = ST_OK;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.map_wr   = MW_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_is_free    = i_action;
                    if (i_action) begin
                        n_state = S_CHK;
                    end else if (!i_stat.fill_zero) begin
                        o_cmd.pop_start = 1'b1;
                        n_state         = S_POP;
                    end else begin
                        n_state = S_SC_START;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_stat.frame_zero || i_stat.out_range) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_load = 1'b1;
                        if (!r_is_free) begin
                            o_cmd.res_status = ST_STALE;
                        end else if (i_stat.frame_zero) begin
                            o_cmd.res_status = ST_NULL_FREE;
                        end else begin
                            o_cmd.res_status = ST_OUT_OF_RANGE;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.mul_idx = 1'b1;
                    n_state       = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                    if (r_is_free) begin
                        if (!i_stat.bit_set) begin
                            o_cmd.res_status = ST_DOUBLE_FREE;
                        end else begin
                            o_cmd.map_wr = MW_FREE;
                            o_cmd.push   = 1'b1;
                        end
                    end else begin
                        if (i_stat.bit_set) begin
                            o_cmd.res_status = ST_STALE;
                        end else begin
                            o_cmd.map_wr = MW_TAKE;
                            o_cmd.grant  = G_FRAME;
                        end
                    end
                end
            end
            S_SC_START: begin
                if (i_stat.n_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OUT_OF_PAGES;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.mul_last = 1'b1;
                    n_state        = S_SC_FIRST;
                end
            end
            S_SC_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = S_SC_RD;
            end
            S_SC_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SC_EVAL;
            end
            S_SC_EVAL: begin
                if (i_stat.word_full) begin
                    if (i_stat.word_first) begin
                        if (i_stat.out_free) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_OUT_OF_PAGES;
                            n_state          = S_IDLE;
                        end
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_SC_RD;
                    end
                end else if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.map_wr   = MW_SCAN;
                    o_cmd.grant    = G_SCAN;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/pfa_datapath.sv
module pfa_datapath import pfa_pkg::*; #(
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int WORD_BITS   = DEF_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [FRAME_W-1:0]    i_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [FRAME_W-1:0]    o_granted_frame,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int BW  = $clog2(WORD_BITS);
    // word = idx / WORD_BITS as (idx * RECIP) >> SH, exact for 20-bit idx
    localparam int SH  = FRAME_W + BW;
    localparam int M_W = FRAME_W + 1;
    localparam int P_W = FRAME_W + M_W;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
    localparam logic [M_W-1:0]     RECIP_M   = M_W'(RECIP);
    localparam logic [N_W-1:0]     MAX_N     = N_W'(MAX_FRAMES);
    localparam logic [N_W-1:0]     WORD_N    = N_W'(WORD_BITS);
    localparam logic [FRAME_W-1:0] WORD_F    = FRAME_W'(WORD_BITS);
    localparam logic [FW-1:0]      FILL_MAX  = FW'(STACK_DEPTH);
    localparam logic [AW-1:0]      LAST_WORD = AW'(MAP_WORDS - 1);

    // config
    logic [FRAME_W-1:0] r_base;
    logic [COUNT_W-1:0] r_count;
    // control
    logic [FW-1:0]      r_fill;
    logic [AW-1:0]      r_clr;
    logic               r_out_valid;
    // payload
    logic [FRAME_W-1:0]  r_frame;
    logic [FRAME_W-1:0]  r_idx;
    logic [P_W-1:0]      r_prod;
    logic [AW-1:0]       r_word;
    logic [BW-1:0]       r_bit;
    logic [N_W-1:0]      r_off;
    logic [WORD_BITS-1:0] r_pad;
    logic [FRAME_W-1:0]  r_out_granted;
    logic [STATUS_W-1:0] r_out_status;

    logic [N_W-1:0]       n_frames;
    logic [FRAME_W-1:0]   mul_x;
    logic [P_W-1:0]       q_wide;
    logic [FRAME_W-1:0]   q_fr;
    logic [FRAME_W-1:0]   rem;
    logic [WORD_BITS-1:0] map_rdata;
    logic [FRAME_W-1:0]   stk_rdata;
    logic [WORD_BITS-1:0] eff;
    logic [WORD_BITS-1:0] low_clr;
    logic [BW-1:0]        low_pos;
    logic                 map_we;
    logic [AW-1:0]        map_waddr;
    logic [WORD_BITS-1:0] map_wdata;
    logic                 map_re;
    logic [AW-1:0]        map_raddr;
    logic                 stk_we;
    logic [FW-1:0]        fill_m1;
    logic [N_W-1:0]       lim;
    logic [FRAME_W-1:0]   zidx;
    logic [FRAME_W-1:0]   zrel;
    logic                 z_in;
    logic [WORD_BITS-1:0] n_pad;
    logic [FRAME_W-1:0]   n_grant;

    assign n_frames = (N_W'(r_count) > MAX_N) ? MAX_N : N_W'(r_count);
    assign mul_x    = i_cmd.mul_last ? FRAME_W'(n_frames - N_W'(1)) : r_idx;
    assign q_wide   = r_prod >> SH;
    assign q_fr     = q_wide[FRAME_W-1:0];
    assign rem      = r_idx - FRAME_W'(q_fr * WORD_F);
    assign fill_m1  = r_fill - FW'(1);

    // Scan masks: bits at or beyond the count, and the bit that maps to frame zero
    assign lim  = n_frames - r_off;
    assign zidx = FRAME_W'(0) - r_base;
    assign zrel = zidx - r_off[FRAME_W-1:0];
    assign z_in = N_W'(zidx) < n_frames;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            n_pad[j] = (N_W'(j) >= lim) || (z_in && (zrel == FRAME_W'(j)));
        end
    end

    assign eff     = map_rdata | r_pad;
    assign low_clr = ~eff & (eff + WORD_BITS'(1));

    always_comb begin
        low_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!eff[j]) begin
                low_pos = BW'(j);
            end
        end
    end

    // Map memory ports
    assign map_re    = i_cmd.split | i_cmd.scan_rd;
    assign map_raddr = i_cmd.split ? q_fr[AW-1:0] : r_word;
    assign map_we    = (i_cmd.map_wr != MW_NONE);
    assign map_waddr = (i_cmd.map_wr == MW_CLEAR) ? r_clr : r_word;

    always_comb begin
        unique case (i_cmd.map_wr)
            MW_FREE: map_wdata = map_rdata & ~(WORD_BITS'(1) << r_bit);
            MW_TAKE: map_wdata = map_rdata | (WORD_BITS'(1) << r_bit);
            MW_SCAN: map_wdata = map_rdata | low_clr;
            default: map_wdata = '0;
        endcase
    end

    assign stk_we = i_cmd.push && (r_fill != FILL_MAX);

    always_comb begin
        unique case (i_cmd.grant)
            G_FRAME: n_grant = r_frame;
            G_SCAN:  n_grant = r_off[FRAME_W-1:0] + FRAME_W'(low_pos) + r_base;
            default: n_grant = '0;
        endcase
    end

    pfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_fill[SW-1:0]),
        .i_wdata (r_frame),
        .i_re    (i_cmd.pop_start),
        .i_raddr (fill_m1[SW-1:0]),
        .o_rdata (stk_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= RST_FRAME_BASE;
            r_count     <= RST_FRAME_COUNT;
            r_fill      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_BASE:  r_base  <= i_cfg_data;
                    CFG_FRAME_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pop_start) begin
                r_fill <= fill_m1;
            end else if (stk_we) begin
                r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_frame <= i_frame;
            r_idx   <= i_frame - r_base;
        end else if (i_cmd.pop_load) begin
            r_frame <= stk_rdata;
            r_idx   <= stk_rdata - r_base;
        end
        if (i_cmd.mul_idx || i_cmd.mul_last) begin
            r_prod <= P_W'(mul_x) * P_W'(RECIP_M);
        end
        if (i_cmd.split) begin
            r_word <= q_fr[AW-1:0];
            r_bit  <= rem[BW-1:0];
        end else if (i_cmd.first) begin
            r_word <= q_fr[AW-1:0];
            r_off  <= N_W'(q_fr) * WORD_N;
        end else if (i_cmd.scan_next) begin
            r_word <= r_word - AW'(1);
            r_off  <= r_off - WORD_N;
        end
        if (i_cmd.scan_rd) begin
            r_pad <= n_pad;
        end
        if (i_cmd.res_load) begin
            r_out_granted <= n_grant;
            r_out_status  <= i_cmd.res_status;
        end
    end

    assign o_stat.fill_zero  = (r_fill == '0);
    assign o_stat.frame_zero = (r_frame == '0);
    assign o_stat.out_range  = (N_W'(r_idx) >= n_frames);
    assign o_stat.bit_set    = map_rdata[r_bit];
    assign o_stat.n_zero     = (n_frames == '0);
    assign o_stat.word_full  = &eff;
    assign o_stat.word_first = (r_word == '0);
    assign o_stat.clr_done   = (r_clr == LAST_WORD);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_granted_frame = r_out_granted;
    assign o_status        = r_out_status;

endmodule

>>> design/page_frame_allocator_top.sv
// Page frame allocator: used-bit map of frames plus a stack of recently freed frames.
// Request channel i_req carries one word per operation: action 0 allocates a frame,
// action 1 frees the given frame. Response channel o_rsp returns exactly one word per
// request: granted_frame (0 unless an allocate succeeds) and a status code.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write frame_base (index 0) or
// frame_count (index 1); write only while no request is in progress.
// A request runs from its accept step to its response load. A null or out-of-range
// free ends at the check, a free goes on through split and evaluate, an allocate
// from the stack pops first, and a map scan examines each map word, top word downward.
// The map sits in a single-port-write RAM with registered reads, so each word
// has a read step followed by an evaluate step; the word/bit split of a frame
// index goes through one registered reciprocal multiplier.
// One request is worked at a time; a new request is accepted as soon as the
// previous one has written its response, even if that response still waits.
// If o_rsp is stalled, a finished result holds in its last step until the
// response register frees up; nothing is dropped.
// Reset (synchronous, active low) clears the stack fill, clear pointer and output
// valid and loads the config defaults; then the map is zeroed one word per cycle
// (MAX_FRAMES/WORD_BITS words, 1024 by default) with i_req.ready low; config writes taken.
module page_frame_allocator_top import pfa_pkg::*; #(
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int WORD_BITS   = DEF_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfa_req_if.sink               i_req,
    pfa_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;   // controller -> datapath
    t_dp_stat stat;  // datapath -> controller
    logic     in_ready;

    // Sequencer: clear pass, request dispatch, stack pop, free/take, word scan
    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_action   (i_req.action),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Map and stack RAMs, config registers, index split, response register
    pfa_datapath #(
        .MAX_FRAMES  (MAX_FRAMES),
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_frame         (i_req.frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_granted_frame (o_rsp.granted_frame),
        .o_status        (o_rsp.status)
    );

    assign i_req.ready = in_ready;

endmodule

>>> design/pfa_checker.sv
module pfa_checker import pfa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [FRAME_W-1:0]  i_granted_frame,
    input logic [STATUS_W-1:0] i_status
);

    // requests accepted whose response word has not yet been taken
    logic [1:0] r_pend, n_pend;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_pend = r_pend;
        if (in_acc && !out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_granted_frame) && $stable(i_status))
        else $error("response word changed while stalled");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_granted_frame == '0))
        else $error("frame granted with an error status");

    a_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != 2'd0))
        else $error("response word without a request");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_pend == 2'd0) || (r_pend == 2'd1))
        else $error("request accepted while another is in work");

    a_clear_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("request taken before the map clear pass");

endmodule

bind page_frame_allocator_top pfa_checker u_pfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_granted_frame (o_rsp.granted_frame),
    .i_status        (o_rsp.status)
);
